// ===== src/ddvw_pkg.sv =====
// ddvw_pkg: widths, constants, status and register codes, shared payload types
// for the differential drive wheel count pipeline
// no dependencies
package ddvw_pkg;

    // configuration register widths and port sizes
    localparam int CPR_W      = 16;
    localparam int DIAM_W     = 20;
    localparam int TRACK_W    = 21;
    localparam int PERIOD_W   = 10;
    localparam int LIMIT_W    = 31;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 31;

    // item fields
    localparam int SPEED_W  = 16;
    localparam int TARGET_W = 32;
    localparam int STATUS_W = 2;

    // internal datapath widths
    localparam int BASE_W   = 39;  // 2 * speed in nm/s and turn * track
    localparam int SUM_W    = 40;
    localparam int MAG_W    = 37;  // magnitude of twice the wheel speed
    localparam int SCALE_W  = 26;  // cpr * period
    localparam int PROD_W   = 63;  // magnitude * scale
    localparam int DEN_W    = 73;  // 2 * pi_q30 * diameter * 10^6
    localparam int LIMDEN_W = 104; // limit * den
    localparam int QUO_W    = 31;
    localparam int REM_W    = DEN_W;
    localparam int Q_SHIFT  = 30;

    // constants
    localparam logic [21:0] NM2_PER_MM = 22'd2000000;
    localparam logic [52:0] DEN_K      = 53'd6746518852000000; // 2 * pi_q30 * 10^6

    // status codes
    localparam logic [STATUS_W-1:0] STATUS_OK   = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_BAD  = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_OVER = 2'd2;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_CPR    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DIAM   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TRACK  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_PERIOD = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_LIMIT  = 3'd4;

    typedef struct packed {
        logic [TRACK_W-1:0]  track;
        logic [SCALE_W-1:0]  scale;
        logic [DEN_W-1:0]    den;
        logic [LIMDEN_W-1:0] limden;
        logic                bad;
    } t_cfg;

    typedef struct packed {
        logic [REM_W-1:0] rem;
        logic [QUO_W-1:0] quo;
        logic             nb;    // next dividend bit to shift in
        logic             neg;
        logic             over;
    } t_wheel;

    typedef struct packed {
        t_wheel l;
        t_wheel r;
    } t_div;

endpackage

// ===== src/ddvw_cfg.sv =====
// ddvw_cfg: configuration registers and a sequencer that derives scale,
// divisor and limit products with one shared multiplier
// depends on ddvw_pkg
module ddvw_cfg import ddvw_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata,
    output t_cfg                  o_cfg,
    output logic                  o_busy
);

    localparam logic [2:0] OP_SCALE = 3'd0;
    localparam logic [2:0] OP_DEN0  = 3'd1;
    localparam logic [2:0] OP_DEN1  = 3'd2;
    localparam logic [2:0] OP_LD0   = 3'd3;
    localparam logic [2:0] OP_LD1   = 3'd4;
    localparam logic [2:0] OP_LD2   = 3'd5;

    localparam int DEN_SPLIT = 27;
    localparam int LD_SPLIT  = 25;

    logic [CPR_W-1:0]    r_cpr;
    logic [DIAM_W-1:0]   r_diam;
    logic [TRACK_W-1:0]  r_track;
    logic [PERIOD_W-1:0] r_period;
    logic [LIMIT_W-1:0]  r_limit;

    logic                r_busy;
    logic [2:0]          r_op;
    logic                r_phase;
    logic [63:0]         r_prod;
    logic [SCALE_W-1:0]  r_scale;
    logic [DEN_W-1:0]    r_den;
    logic [LIMDEN_W-1:0] r_limden;

    logic [31:0] mul_a;
    logic [31:0] mul_b;

    always_comb begin
        unique case (r_op)
            OP_SCALE: begin
                mul_a = 32'(r_cpr);
                mul_b = 32'(r_period);
            end
            OP_DEN0: begin
                mul_a = 32'(r_diam);
                mul_b = 32'(DEN_K[DEN_SPLIT-1:0]);
            end
            OP_DEN1: begin
                mul_a = 32'(r_diam);
                mul_b = 32'(DEN_K[52:DEN_SPLIT]);
            end
            OP_LD0: begin
                mul_a = 32'(r_limit);
                mul_b = 32'(r_den[LD_SPLIT-1:0]);
            end
            OP_LD1: begin
                mul_a = 32'(r_limit);
                mul_b = 32'(r_den[2*LD_SPLIT-1:LD_SPLIT]);
            end
            OP_LD2: begin
                mul_a = 32'(r_limit);
                mul_b = 32'(r_den[DEN_W-1:2*LD_SPLIT]);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cpr    <= CPR_W'(1024);
            r_diam   <= DIAM_W'(100000);
            r_track  <= TRACK_W'(300000);
            r_period <= PERIOD_W'(1);
            r_limit  <= LIMIT_W'(10000);
            r_busy   <= 1'b1;
            r_op     <= OP_SCALE;
            r_phase  <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_CPR:    r_cpr    <= i_cfg_wdata[CPR_W-1:0];
                REG_DIAM:   r_diam   <= i_cfg_wdata[DIAM_W-1:0];
                REG_TRACK:  r_track  <= i_cfg_wdata[TRACK_W-1:0];
                REG_PERIOD: r_period <= i_cfg_wdata[PERIOD_W-1:0];
                REG_LIMIT:  r_limit  <= i_cfg_wdata[LIMIT_W-1:0];
                default: ;
            endcase
            r_busy  <= 1'b1;
            r_op    <= OP_SCALE;
            r_phase <= 1'b0;
        end else if (r_busy) begin
            r_phase <= ~r_phase;
            if (r_phase) begin
                if (r_op == OP_LD2) begin
                    r_busy <= 1'b0;
                end else begin
                    r_op <= r_op + 3'd1;
                end
            end
        end
    end

    // multiply on phase 0, accumulate on phase 1
    always_ff @(posedge i_clk) begin
        if (!r_phase) begin
            r_prod <= mul_a * mul_b;
        end else begin
            unique case (r_op)
                OP_SCALE: r_scale  <= r_prod[SCALE_W-1:0];
                OP_DEN0:  r_den    <= DEN_W'(r_prod);
                OP_DEN1:  r_den    <= r_den + (DEN_W'(r_prod) << DEN_SPLIT);
                OP_LD0:   r_limden <= LIMDEN_W'(r_prod);
                OP_LD1:   r_limden <= r_limden + (LIMDEN_W'(r_prod) << LD_SPLIT);
                OP_LD2:   r_limden <= r_limden + (LIMDEN_W'(r_prod) << (2 * LD_SPLIT));
                default: ;
            endcase
        end
    end

    assign o_cfg.track  = r_track;
    assign o_cfg.scale  = r_scale;
    assign o_cfg.den    = r_den;
    assign o_cfg.limden = r_limden;
    assign o_cfg.bad    = (r_cpr == '0) || (r_diam == '0) || (r_track == '0) ||
                          (r_period == '0) || (r_limit == '0);
    assign o_busy       = r_busy;

endmodule

// ===== src/ddvw_front.sv =====
// ddvw_front: four pipeline stages from command to scaled wheel speeds,
// limit check and divider start values
// depends on ddvw_pkg
module ddvw_front import ddvw_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_cfg               i_cfg,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [SPEED_W-1:0] i_lin,
    input  logic [SPEED_W-1:0] i_turn,
    output logic               o_valid,
    input  logic               i_stall,
    output t_div               o_data
);

    logic                     r1_v, r2_v, r3_v, r4_v;
    logic                     s1, s2, s3, s4;
    logic signed [BASE_W-1:0] r1_base, r1_rot;
    logic [MAG_W-1:0]         r2_mag_l, r2_mag_r;
    logic                     r2_neg_l, r2_neg_r;
    logic [PROD_W-1:0]        r3_x_l, r3_x_r;
    logic                     r3_neg_l, r3_neg_r;
    t_div                     r4_data;

    logic signed [SUM_W-1:0]  sum_l, sum_r, abs_l, abs_r;
    logic [LIMDEN_W-1:0]      num_l, num_r;

    assign s4      = r4_v & i_stall;
    assign s3      = r3_v & s4;
    assign s2      = r2_v & s3;
    assign s1      = r1_v & s2;
    assign o_stall = s1;

    // stage 1: twice the linear speed and the rotation term
    always_ff @(posedge i_clk) begin
        if (!s1) begin
            r1_base <= $signed(i_lin) * $signed(NM2_PER_MM);
            r1_rot  <= $signed(i_turn) * $signed({1'b0, i_cfg.track});
        end
    end

    // stage 2: wheel sums, sign and magnitude
    always_comb begin
        sum_l = SUM_W'(r1_base) - SUM_W'(r1_rot);
        sum_r = SUM_W'(r1_base) + SUM_W'(r1_rot);
        abs_l = sum_l[SUM_W-1] ? -sum_l : sum_l;
        abs_r = sum_r[SUM_W-1] ? -sum_r : sum_r;
    end

    always_ff @(posedge i_clk) begin
        if (!s2) begin
            r2_mag_l <= abs_l[MAG_W-1:0];
            r2_mag_r <= abs_r[MAG_W-1:0];
            r2_neg_l <= sum_l[SUM_W-1];
            r2_neg_r <= sum_r[SUM_W-1];
        end
    end

    // stage 3: scale by counts per rev times period
    always_ff @(posedge i_clk) begin
        if (!s3) begin
            r3_x_l   <= PROD_W'(r2_mag_l * i_cfg.scale);
            r3_x_r   <= PROD_W'(r2_mag_r * i_cfg.scale);
            r3_neg_l <= r2_neg_l;
            r3_neg_r <= r2_neg_r;
        end
    end

    // stage 4: exact limit check, divider start
    assign num_l = LIMDEN_W'({r3_x_l, Q_SHIFT'(0)});
    assign num_r = LIMDEN_W'({r3_x_r, Q_SHIFT'(0)});

    always_ff @(posedge i_clk) begin
        if (!s4) begin
            r4_data.l.rem  <= REM_W'(r3_x_l[PROD_W-1:1]);
            r4_data.l.quo  <= '0;
            r4_data.l.nb   <= r3_x_l[0];
            r4_data.l.neg  <= r3_neg_l;
            r4_data.l.over <= num_l > i_cfg.limden;
            r4_data.r.rem  <= REM_W'(r3_x_r[PROD_W-1:1]);
            r4_data.r.quo  <= '0;
            r4_data.r.nb   <= r3_x_r[0];
            r4_data.r.neg  <= r3_neg_r;
            r4_data.r.over <= num_r > i_cfg.limden;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
            r2_v <= 1'b0;
            r3_v <= 1'b0;
            r4_v <= 1'b0;
        end else begin
            if (!s1) r1_v <= i_valid;
            if (!s2) r2_v <= r1_v;
            if (!s3) r3_v <= r2_v;
            if (!s4) r4_v <= r3_v;
        end
    end

    assign o_valid = r4_v;
    assign o_data  = r4_data;

endmodule

// ===== src/ddvw_div_step.sv =====
// ddvw_div_step: one restoring division step for both wheels, registered
// depends on ddvw_pkg
module ddvw_div_step import ddvw_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic [DEN_W-1:0] i_den,
    input  logic             i_valid,
    output logic             o_stall,
    input  t_div             i_data,
    output logic             o_valid,
    input  logic             i_stall,
    output t_div             o_data
);

    logic r_valid;
    t_div r_data;

    function automatic t_wheel div_step(t_wheel w, logic [DEN_W-1:0] den);
        logic [REM_W:0] trial;
        t_wheel         res;
        trial  = {w.rem, w.nb};
        res    = w;
        res.nb = 1'b0;
        if (trial >= {1'b0, den}) begin
            res.rem = REM_W'(trial - {1'b0, den});
            res.quo = {w.quo[QUO_W-2:0], 1'b1};
        end else begin
            res.rem = trial[REM_W-1:0];
            res.quo = {w.quo[QUO_W-2:0], 1'b0};
        end
        return res;
    endfunction

    assign o_stall = r_valid & i_stall;

    always_ff @(posedge i_clk) begin
        if (!o_stall) begin
            r_data.l <= div_step(i_data.l, i_den);
            r_data.r <= div_step(i_data.r, i_den);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (!o_stall) begin
            r_valid <= i_valid;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

// ===== src/ddvw_back.sv =====
// ddvw_back: rounding stage and output register with status and sign
// depends on ddvw_pkg
module ddvw_back import ddvw_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_cfg                i_cfg,
    input  logic                i_valid,
    output logic                o_stall,
    input  t_div                i_data,
    output logic                o_valid,
    input  logic                i_stall,
    output logic [TARGET_W-1:0] o_left,
    output logic [TARGET_W-1:0] o_right,
    output logic [STATUS_W-1:0] o_status
);

    logic                r1_v, r2_v;
    logic                s1, s2;
    logic [TARGET_W-1:0] r1_rnd_l, r1_rnd_r;
    logic                r1_neg_l, r1_neg_r, r1_over;
    logic [TARGET_W-1:0] r2_left, r2_right;
    logic [STATUS_W-1:0] r2_status;

    logic                up_l, up_r;
    logic [STATUS_W-1:0] n_status;

    assign s2      = r2_v & i_stall;
    assign s1      = r1_v & s2;
    assign o_stall = s1;

    // half away from zero on the magnitude
    assign up_l = {i_data.l.rem, 1'b0} >= {1'b0, i_cfg.den};
    assign up_r = {i_data.r.rem, 1'b0} >= {1'b0, i_cfg.den};

    always_ff @(posedge i_clk) begin
        if (!s1) begin
            r1_rnd_l <= TARGET_W'(i_data.l.quo) + TARGET_W'(up_l);
            r1_rnd_r <= TARGET_W'(i_data.r.quo) + TARGET_W'(up_r);
            r1_neg_l <= i_data.l.neg;
            r1_neg_r <= i_data.r.neg;
            r1_over  <= i_data.l.over | i_data.r.over;
        end
    end

    always_comb begin
        priority if (i_cfg.bad) begin
            n_status = STATUS_BAD;
        end else if (r1_over) begin
            n_status = STATUS_OVER;
        end else begin
            n_status = STATUS_OK;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!s2) begin
            r2_status <= n_status;
            if (n_status != STATUS_OK) begin
                r2_left  <= '0;
                r2_right <= '0;
            end else begin
                r2_left  <= r1_neg_l ? -r1_rnd_l : r1_rnd_l;
                r2_right <= r1_neg_r ? -r1_rnd_r : r1_rnd_r;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
            r2_v <= 1'b0;
        end else begin
            if (!s1) r1_v <= i_valid;
            if (!s2) r2_v <= r1_v;
        end
    end

    assign o_valid  = r2_v;
    assign o_left   = r2_left;
    assign o_right  = r2_right;
    assign o_status = r2_status;

endmodule

// ===== src/diff_drive_velocity_to_wheel_counts.sv =====
// diff_drive_velocity_to_wheel_counts: differential drive inverse kinematics top
// depends on ddvw_pkg, ddvw_cfg, ddvw_front, ddvw_div_step, ddvw_back
//
// usage
// - config port: i_cfg_we with i_cfg_index 0..4 writes counts per rev, wheel
//   diameter, track width, period and count limit; other indexes are ignored
// - each write starts a recompute of scale and divisor terms on one
//   shared multiplier; o_in_stall is high meanwhile
// - input channel: i_in_valid / o_in_stall, transfer of speed and turn rate
// - output channel: o_out_valid / i_out_stall, transfer of both targets and status
// - pipeline of 4 front stages, 31 restoring division stages (one
//   quotient bit per stage), rounding stage and output register
// - throughput one command per cycle unless stalled or busy; each stage holds
//   its item while the stage after it is full and stalled, empty stages still fill
// - reset clears all valid bits, loads the register defaults and runs the
//   recompute before the first command is taken
// - status 1 on any zero register, 2 when either exact count exceeds the
//   limit; both targets are zero in those cases
module diff_drive_velocity_to_wheel_counts import ddvw_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic [SPEED_W-1:0]    i_linear_speed_mm_s,
    input  logic [SPEED_W-1:0]    i_turn_rate_mrad_s,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic [TARGET_W-1:0]   o_left_count_target,
    output logic [TARGET_W-1:0]   o_right_count_target,
    output logic [STATUS_W-1:0]   o_status
);

    t_cfg cfg;
    logic busy;
    logic front_stall;

    logic v [0:QUO_W];
    logic s [0:QUO_W];
    t_div d [0:QUO_W];

    ddvw_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata),
        .o_cfg       (cfg),
        .o_busy      (busy)
    );

    ddvw_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg),
        .i_valid (i_in_valid & ~busy),
        .o_stall (front_stall),
        .i_lin   (i_linear_speed_mm_s),
        .i_turn  (i_turn_rate_mrad_s),
        .o_valid (v[0]),
        .i_stall (s[0]),
        .o_data  (d[0])
    );

    assign o_in_stall = busy | front_stall;

    for (genvar k = 0; k < QUO_W; k++) begin : g_div
        ddvw_div_step u_step (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_den   (cfg.den),
            .i_valid (v[k]),
            .o_stall (s[k]),
            .i_data  (d[k]),
            .o_valid (v[k+1]),
            .i_stall (s[k+1]),
            .o_data  (d[k+1])
        );
    end

    ddvw_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (cfg),
        .i_valid  (v[QUO_W]),
        .o_stall  (s[QUO_W]),
        .i_data   (d[QUO_W]),
        .o_valid  (o_out_valid),
        .i_stall  (i_out_stall),
        .o_left   (o_left_count_target),
        .o_right  (o_right_count_target),
        .o_status (o_status)
    );

endmodule

// ===== tb/ddvw_checker.sv =====
// ddvw_checker: watches the config port and both channels, predicts the wheel targets
// of each command and compares every output transfer against them
// depends on ddvw_pkg
`timescale 1ns / 100ps

module ddvw_checker import ddvw_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata,
    input  logic                  i_in_valid,
    input  logic                  i_in_stall,
    input  logic [SPEED_W-1:0]    i_linear_speed_mm_s,
    input  logic [SPEED_W-1:0]    i_turn_rate_mrad_s,
    input  logic                  i_out_valid,
    input  logic                  i_out_stall,
    input  logic [TARGET_W-1:0]   i_left_count_target,
    input  logic [TARGET_W-1:0]   i_right_count_target,
    input  logic [STATUS_W-1:0]   i_status,
    output int                    o_pending,
    output int                    o_fail_count
);

    localparam logic [31:0] PI_Q30 = 32'hC90FDAA2;

    typedef struct packed {
        logic [TARGET_W-1:0] left;
        logic [TARGET_W-1:0] right;
        logic [STATUS_W-1:0] status;
    } t_targets;

    logic [CPR_W-1:0]    cpr_r;
    logic [DIAM_W-1:0]   diam_r;
    logic [TRACK_W-1:0]  track_r;
    logic [PERIOD_W-1:0] period_r;
    logic [LIMIT_W-1:0]  limit_r;

    t_targets target_q[$];
    int       fail_count = 0;

    initial begin
        o_pending    = 0;
        o_fail_count = 0;
    end

    // returns 1 when the exact count is beyond the limit
    function automatic bit wheel_target(longint v2, output logic [TARGET_W-1:0] cnt);
        bit           neg;
        logic [63:0]  mag;
        logic [127:0] num, den, q, r, rounded;
        neg = v2 < 0;
        mag = neg ? 64'(-v2) : 64'(v2);
        num = 128'(mag) * 128'(cpr_r) * 128'(period_r);
        num = num << 30;
        den = 128'(diam_r) * 128'(PI_Q30) * 128'd2000000;
        q = num / den;
        r = num % den;
        cnt = '0;
        if (q > 128'(limit_r) || (q == 128'(limit_r) && r != 0))
            return 1'b1;
        rounded = q + (((r << 1) >= den) ? 128'd1 : 128'd0);
        cnt = neg ? -rounded[TARGET_W-1:0] : rounded[TARGET_W-1:0];
        return 1'b0;
    endfunction

    function automatic t_targets predict_targets(logic [SPEED_W-1:0] lin,
                                                 logic [SPEED_W-1:0] turn);
        t_targets            res;
        longint              base, rot;
        logic [TARGET_W-1:0] lc, rc;
        bit                  over_l, over_r;
        res = '0;
        res.status = STATUS_OK;
        if (cpr_r == 0 || diam_r == 0 || track_r == 0 || period_r == 0 || limit_r == 0) begin
            res.status = STATUS_BAD;
        end else begin
            base = longint'($signed(lin)) * 64'sd2000000;
            rot = longint'($signed(turn)) * longint'(track_r);
            over_l = wheel_target(base - rot, lc);
            over_r = wheel_target(base + rot, rc);
            if (over_l || over_r) begin
                res.status = STATUS_OVER;
            end else begin
                res.left = lc;
                res.right = rc;
            end
        end
        return res;
    endfunction

    task automatic check_field(string fname, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            fail_count++;
            if (fail_count <= 10)
                $display("mismatch %s: expected %0h actual %0h", fname, want, got);
        end
    endtask

    always @(posedge i_clk) begin
        t_targets want;
        if (!i_rst_n) begin
            cpr_r    = 16'd1024;
            diam_r   = 20'd100000;
            track_r  = 21'd300000;
            period_r = 10'd1;
            limit_r  = 31'd10000;
            target_q.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (target_q.size() == 0) begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("unexpected transfer: left %0h right %0h status %0h",
                                 i_left_count_target, i_right_count_target, i_status);
                end else begin
                    want = target_q.pop_front();
                    check_field("left", want.left, i_left_count_target);
                    check_field("right", want.right, i_right_count_target);
                    check_field("status", 32'(want.status), 32'(i_status));
                end
            end
            if (i_in_valid && !i_in_stall)
                target_q.push_back(predict_targets(i_linear_speed_mm_s, i_turn_rate_mrad_s));
            if (i_cfg_we) begin
                case (i_cfg_index)
                    REG_CPR:    cpr_r    = i_cfg_wdata[CPR_W-1:0];
                    REG_DIAM:   diam_r   = i_cfg_wdata[DIAM_W-1:0];
                    REG_TRACK:  track_r  = i_cfg_wdata[TRACK_W-1:0];
                    REG_PERIOD: period_r = i_cfg_wdata[PERIOD_W-1:0];
                    REG_LIMIT:  limit_r  = i_cfg_wdata[LIMIT_W-1:0];
                    default: ;
                endcase
            end
        end
        o_pending <= target_q.size();
        o_fail_count <= fail_count;
    end

endmodule

// ===== tb/diff_drive_velocity_to_wheel_counts_tb.sv =====
// diff_drive_velocity_to_wheel_counts_tb: clock, reset, config phases and command stimulus
// with bursty sender and stalling receiver; verdict from the checker's failure count
// depends on ddvw_pkg, ddvw_checker and the block under test
`timescale 1ns / 100ps

module diff_drive_velocity_to_wheel_counts_tb import ddvw_pkg::*;;

    localparam int LIMIT_CYCLES = 400000;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_wdata = '0;
    logic                  i_in_valid = 1'b0;
    logic                  o_in_stall;
    logic [SPEED_W-1:0]    i_linear_speed_mm_s = '0;
    logic [SPEED_W-1:0]    i_turn_rate_mrad_s = '0;
    logic                  o_out_valid;
    logic                  i_out_stall = 1'b0;
    logic [TARGET_W-1:0]   o_left_count_target;
    logic [TARGET_W-1:0]   o_right_count_target;
    logic [STATUS_W-1:0]   o_status;

    int pending;
    int fail_count;
    int cycles = 0;
    int burst_left = 0;
    int hold_left = 0;
    int seg_left = 0;
    int stall_pct = 0;
    bit hold_req = 1'b0;
    bit hold_done = 1'b0;

    diff_drive_velocity_to_wheel_counts uut (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_cfg_we             (i_cfg_we),
        .i_cfg_index          (i_cfg_index),
        .i_cfg_wdata          (i_cfg_wdata),
        .i_in_valid           (i_in_valid),
        .o_in_stall           (o_in_stall),
        .i_linear_speed_mm_s  (i_linear_speed_mm_s),
        .i_turn_rate_mrad_s   (i_turn_rate_mrad_s),
        .o_out_valid          (o_out_valid),
        .i_out_stall          (i_out_stall),
        .o_left_count_target  (o_left_count_target),
        .o_right_count_target (o_right_count_target),
        .o_status             (o_status)
    );

    ddvw_checker checker_i (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_cfg_we             (i_cfg_we),
        .i_cfg_index          (i_cfg_index),
        .i_cfg_wdata          (i_cfg_wdata),
        .i_in_valid           (i_in_valid),
        .i_in_stall           (o_in_stall),
        .i_linear_speed_mm_s  (i_linear_speed_mm_s),
        .i_turn_rate_mrad_s   (i_turn_rate_mrad_s),
        .i_out_valid          (o_out_valid),
        .i_out_stall          (i_out_stall),
        .i_left_count_target  (o_left_count_target),
        .i_right_count_target (o_right_count_target),
        .i_status             (o_status),
        .o_pending            (pending),
        .o_fail_count         (fail_count)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > LIMIT_CYCLES) begin
            $display("FAIL");
            $finish;
        end
    end

    // receiver: random stall stretches, one long hold-off on request
    always @(posedge i_clk) begin
        if (hold_left != 0) begin
            hold_left--;
            i_out_stall <= 1'b1;
        end else if (hold_req && !hold_done) begin
            hold_done = 1'b1;
            hold_left = 400;
            i_out_stall <= 1'b1;
        end else begin
            if (seg_left == 0) begin
                seg_left = $urandom_range(5, 60);
                case ($urandom_range(0, 3))
                    0: stall_pct = 0;
                    1: stall_pct = 25;
                    2: stall_pct = 50;
                    default: stall_pct = 85;
                endcase
            end else begin
                seg_left--;
            end
            i_out_stall <= ($urandom_range(0, 99) < stall_pct);
        end
    end

    task automatic send_cmd(logic [SPEED_W-1:0] lin, logic [SPEED_W-1:0] turn);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15);
            if (gap != 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 40);
        end
        i_in_valid <= 1'b1;
        i_linear_speed_mm_s <= lin;
        i_turn_rate_mrad_s <= turn;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        burst_left--;
    endtask

    // drop valid and wait until every expected transfer is back
    task automatic drain();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0 || o_in_stall);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wdata <= data;
        @(posedge i_clk);
    endtask

    task automatic end_writes();
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    function automatic logic [SPEED_W-1:0] pick_speed();
        case ($urandom_range(0, 5))
            0: begin
                case ($urandom_range(0, 4))
                    0: return 16'h7FFF;
                    1: return 16'h8000;
                    2: return 16'h0000;
                    3: return 16'h0001;
                    default: return 16'hFFFF;
                endcase
            end
            1, 2: return 16'($urandom_range(0, 600) - 300);
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic random_cfg(int k);
        case (k)
            0: begin
                write_reg(REG_CPR, 31'd1);
                write_reg(REG_DIAM, 31'd1);
                write_reg(REG_TRACK, 31'd1);
                write_reg(REG_PERIOD, 31'd1);
                write_reg(REG_LIMIT, 31'd1);
            end
            1, 2: begin
                write_reg(REG_CPR, 31'h0000FFFF);
                write_reg(REG_DIAM, 31'h000FFFFF);
                write_reg(REG_TRACK, 31'h001FFFFF);
                write_reg(REG_PERIOD, 31'h000003FF);
                write_reg(REG_LIMIT, (k == 1) ? 31'h7FFFFFFF : 31'($urandom_range(1, 50000)));
            end
            default: begin
                if ($urandom_range(0, 2) == 0)
                    write_reg(REG_CPR, 31'($urandom));
                else
                    write_reg(REG_CPR, 31'($urandom_range(1, 4096)));
                if ($urandom_range(0, 2) == 0)
                    write_reg(REG_DIAM, 31'($urandom));
                else
                    write_reg(REG_DIAM, 31'($urandom_range(1000, 1048575)));
                if ($urandom_range(0, 2) == 0)
                    write_reg(REG_TRACK, 31'($urandom));
                else
                    write_reg(REG_TRACK, 31'($urandom_range(1000, 2097151)));
                write_reg(REG_PERIOD, 31'($urandom_range(1, 1023)));
                case ($urandom_range(0, 2))
                    0: write_reg(REG_LIMIT, 31'($urandom_range(1, 100)));
                    1: write_reg(REG_LIMIT, 31'($urandom_range(1, 100000)));
                    default: write_reg(REG_LIMIT, 31'($urandom));
                endcase
                write_reg(3'($urandom_range(5, 7)), 31'($urandom));
            end
        endcase
        end_writes();
    endtask

    initial begin
        int n;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // defaults: extremes of both fields and rounding near one half
        send_cmd(16'h0000, 16'h0000);
        send_cmd(16'h7FFF, 16'h0000);
        send_cmd(16'h8000, 16'h0000);
        send_cmd(16'h0000, 16'h7FFF);
        send_cmd(16'h0000, 16'h8000);
        send_cmd(16'h7FFF, 16'h7FFF);
        send_cmd(16'h8000, 16'h8000);
        send_cmd(16'h7FFF, 16'h8000);
        send_cmd(16'h8000, 16'h7FFF);
        send_cmd(16'h0001, 16'hFFFF);
        send_cmd(16'd153, 16'h0000);
        send_cmd(16'd154, 16'h0000);
        send_cmd(-16'sd154, 16'h0000);
        drain();

        // limit of one: exact count just above the limit still fails
        write_reg(REG_LIMIT, 31'd1);
        end_writes();
        send_cmd(16'd306, 16'h0000);
        send_cmd(16'd307, 16'h0000);
        send_cmd(-16'sd307, 16'h0000);
        send_cmd(-16'sd306, 16'h0000);
        send_cmd(16'h0000, 16'd2046);
        send_cmd(16'h0000, -16'sd2045);
        drain();
        write_reg(REG_LIMIT, 31'd10000);
        end_writes();

        // each register zero in turn; cpr zero via high bits that are dropped
        for (int i = 0; i < 5; i++) begin
            case (i)
                0: write_reg(REG_CPR, 31'h7FFF0000);
                1: write_reg(REG_DIAM, 31'd0);
                2: write_reg(REG_TRACK, 31'd0);
                3: write_reg(REG_PERIOD, 31'd0);
                default: write_reg(REG_LIMIT, 31'd0);
            endcase
            end_writes();
            send_cmd(pick_speed(), pick_speed());
            drain();
            case (i)
                0: write_reg(REG_CPR, 31'd1024);
                1: write_reg(REG_DIAM, 31'd100000);
                2: write_reg(REG_TRACK, 31'd300000);
                3: write_reg(REG_PERIOD, 31'd1);
                default: write_reg(REG_LIMIT, 31'd10000);
            endcase
            end_writes();
        end

        for (int k = 0; k < 8; k++) begin
            random_cfg(k);
            if (k == 3)
                hold_req = 1'b1;
            n = $urandom_range(95, 115);
            repeat (n) send_cmd(pick_speed(), pick_speed());
            drain();
        end

        repeat (50) @(posedge i_clk);
        if (fail_count == 0 && pending == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
